// ----- sv/lbcq_pkg.sv -----
// shared types and codes for the linked block character queue
// no dependencies; imported by every module of the block
package lbcq_pkg;

  localparam logic [1:0] OP_TAKE   = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_NOFREE = 2'd2;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 11;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DESC,
    S_TAKE,
    S_GRAB,
    S_LINK,
    S_REM,
    S_WALK,
    S_UNLINK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [1:0]        queue_id;
    logic [BYTE_W-1:0] byte_in;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  byte_out;
    logic [1:0]         status;
    logic [COUNT_W-1:0] queue_bytes;
    logic [COUNT_W-1:0] pool_free_bytes;
  } out_t;

endpackage

// ----- sv/lbcq_store.sv -----
// byte data memory of the block pool, one port, registered read
// address is block number times block size plus offset; uses lbcq_pkg
module lbcq_store #(
  parameter int NUM_BLOCKS  = 64,
  parameter int BLOCK_BYTES = 16
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic                                 we,
  input  logic [$clog2(NUM_BLOCKS+1)-1:0]      blk,
  input  logic [$clog2(BLOCK_BYTES+1)-1:0]     off,
  input  logic [lbcq_pkg::BYTE_W-1:0]          wdata,
  output logic [lbcq_pkg::BYTE_W-1:0]          rdata
);
  import lbcq_pkg::*;

  localparam int DEPTH = NUM_BLOCKS * BLOCK_BYTES;
  localparam int SAW   = $clog2(DEPTH);
  localparam int LAW   = $clog2(NUM_BLOCKS);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [SAW-1:0]    addr;

  assign addr = SAW'(blk[LAW-1:0]) * SAW'(BLOCK_BYTES) + SAW'(off);

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

// ----- sv/lbcq_link.sv -----
// next-block link memory shared by the free list and all queue chains
// one write and one registered read per cycle; uses lbcq_pkg
module lbcq_link #(
  parameter int NUM_BLOCKS = 64
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [$clog2(NUM_BLOCKS)-1:0]       rd_addr,
  output logic [$clog2(NUM_BLOCKS+1)-1:0]     rd_data,
  input  logic                                wr_en,
  input  logic [$clog2(NUM_BLOCKS)-1:0]       wr_addr,
  input  logic [$clog2(NUM_BLOCKS+1)-1:0]     wr_data
);
  import lbcq_pkg::*;

  localparam int BW = $clog2(NUM_BLOCKS + 1);

  logic [BW-1:0] mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/lbcq_ctrl.sv -----
// sequencer: queue descriptor memory, free list head and capacity,
// and the access steps to lbcq_store and lbcq_link; uses lbcq_pkg
module lbcq_ctrl #(
  parameter int NUM_BLOCKS  = 64,
  parameter int BLOCK_BYTES = 16,
  parameter int NUM_QUEUES  = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  lbcq_pkg::in_t  in_data,
  output logic           idle,
  input  logic           slot_free,
  output logic           res_load,
  output lbcq_pkg::out_t res
);
  import lbcq_pkg::*;

  localparam int BW   = $clog2(NUM_BLOCKS + 1);
  localparam int LAW  = $clog2(NUM_BLOCKS);
  localparam int OW   = $clog2(BLOCK_BYTES + 1);
  localparam int CW   = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
  localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int MAXN = (NUM_BLOCKS > NUM_QUEUES) ? NUM_BLOCKS : NUM_QUEUES;
  localparam int IW   = $clog2(MAXN);

  localparam logic [BW-1:0] NULL_BLK = BW'(NUM_BLOCKS);
  localparam logic [OW-1:0] BLK_FULL = OW'(BLOCK_BYTES);
  localparam logic [CW-1:0] BLK_CAP  = CW'(BLOCK_BYTES);
  localparam logic [CW-1:0] POOL_CAP = CW'(NUM_BLOCKS * BLOCK_BYTES);

  typedef struct packed {
    logic [BW-1:0] front_blk;
    logic [OW-1:0] front_off;
    logic [BW-1:0] back_blk;
    logic [OW-1:0] back_off;
    logic [CW-1:0] count;
  } desc_t;

  localparam desc_t DESC_CLEAR = '{
    front_blk: NULL_BLK, front_off: '0, back_blk: NULL_BLK, back_off: '0, count: '0
  };

  state_t state_r, state_nxt;

  logic [1:0]        op_r, op_nxt;
  logic [QW-1:0]     q_r, q_nxt, q_in;
  logic [BYTE_W-1:0] bin_r, bin_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [1:0]        status_r, status_nxt;
  desc_t             d_r, d_nxt;
  logic [BW-1:0]     free_head_r, free_head_nxt;
  logic [CW-1:0]     free_cap_r, free_cap_nxt;
  logic [BW-1:0]     new_blk_r, new_blk_nxt;
  logic [BW-1:0]     prev_r, prev_nxt;
  logic [BW-1:0]     steps_r, steps_nxt;
  logic [IW-1:0]     init_r, init_nxt;

  // descriptor memory
  desc_t         desc_mem [NUM_QUEUES];
  desc_t         desc_rd_r;
  logic          desc_we;
  logic [QW-1:0] desc_waddr;
  desc_t         desc_wdata;

  // link and store ports
  logic           link_re, link_we;
  logic [LAW-1:0] link_raddr, link_waddr;
  logic [BW-1:0]  link_wdata, link_rdata;
  logic           st_en, st_we;
  logic [BW-1:0]  st_blk;
  logic [OW-1:0]  st_off;
  logic [BYTE_W-1:0] st_rdata;

  logic in_acc;
  logic dd_empty, dd_need_blk, rem_empty, pool_empty;
  logic grab_new_chain, take_last, take_wrap, rem_last;
  logic walk_found, walk_stop;
  logic [OW-1:0] front_inc;

  assign idle   = (state_r == S_IDLE);
  assign in_acc = in_valid && idle;

  // queue index folds modulo the queue count
  always_comb begin
    if (NUM_QUEUES == 1) begin
      q_in = '0;
    end else if (NUM_QUEUES < 4 && int'(in_data.queue_id) >= NUM_QUEUES) begin
      q_in = QW'(int'(in_data.queue_id) - NUM_QUEUES);
    end else begin
      q_in = QW'(in_data.queue_id);
    end
  end

  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[desc_waddr] <= desc_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      desc_rd_r <= desc_mem[q_in];
    end
  end

  lbcq_link #(.NUM_BLOCKS(NUM_BLOCKS)) u_link (
    .clk     (clk),
    .rd_en   (link_re),
    .rd_addr (link_raddr),
    .rd_data (link_rdata),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata)
  );

  lbcq_store #(.NUM_BLOCKS(NUM_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES)) u_store (
    .clk   (clk),
    .en    (st_en),
    .we    (st_we),
    .blk   (st_blk),
    .off   (st_off),
    .wdata (bin_r),
    .rdata (st_rdata)
  );

  assign pool_empty     = (free_head_r == NULL_BLK);
  assign dd_empty       = (desc_rd_r.count == '0);
  assign dd_need_blk    = dd_empty || (desc_rd_r.back_blk == NULL_BLK) ||
                          (desc_rd_r.back_off >= BLK_FULL);
  assign rem_empty      = dd_empty || (desc_rd_r.back_off == '0);
  assign grab_new_chain = (d_r.count == '0) || (d_r.back_blk == NULL_BLK);
  assign front_inc      = d_r.front_off + OW'(1);
  assign take_last      = (d_r.count == CW'(1));
  assign take_wrap      = (front_inc >= BLK_FULL);
  assign rem_last       = (d_r.count == CW'(1));
  assign walk_found     = (link_rdata == d_r.back_blk);
  assign walk_stop      = (steps_r == NULL_BLK) || (link_rdata >= NULL_BLK);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (init_r == IW'(MAXN - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_nxt = S_DESC;
      end
      S_DESC: begin
        unique case (op_r)
          OP_TAKE:   state_nxt = dd_empty ? S_DONE : S_TAKE;
          OP_APPEND: state_nxt = (dd_need_blk && !pool_empty) ? S_GRAB : S_DONE;
          OP_REMOVE: state_nxt = rem_empty ? S_DONE : S_REM;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_TAKE:   state_nxt = S_DONE;
      S_GRAB:   state_nxt = grab_new_chain ? S_DONE : S_LINK;
      S_LINK:   state_nxt = S_DONE;
      S_REM: begin
        if (!rem_last && d_r.back_off == '0) state_nxt = S_WALK;
        else state_nxt = S_DONE;
      end
      S_WALK: begin
        if (walk_found) state_nxt = S_UNLINK;
        else if (walk_stop) state_nxt = S_DONE;
      end
      S_UNLINK: state_nxt = S_DONE;
      S_DONE: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_INIT;
    endcase
  end

  // datapath and memory accesses
  always_comb begin
    op_nxt        = op_r;
    q_nxt         = q_r;
    bin_nxt       = bin_r;
    byte_nxt      = byte_r;
    status_nxt    = status_r;
    d_nxt         = d_r;
    free_head_nxt = free_head_r;
    free_cap_nxt  = free_cap_r;
    new_blk_nxt   = new_blk_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    init_nxt      = init_r;
    link_re       = 1'b0;
    link_raddr    = '0;
    link_we       = 1'b0;
    link_waddr    = '0;
    link_wdata    = '0;
    st_en         = 1'b0;
    st_we         = 1'b0;
    st_blk        = '0;
    st_off        = '0;
    desc_we       = 1'b0;
    desc_waddr    = q_r;
    desc_wdata    = d_r;
    res_load      = 1'b0;

    unique case (state_r)
      S_INIT: begin
        init_nxt = init_r + IW'(1);
        // initial free list chains every block to the next
        if (32'(init_r) < 32'(NUM_BLOCKS)) begin
          link_we    = 1'b1;
          link_waddr = LAW'(init_r);
          link_wdata = BW'(init_r) + BW'(1);
        end
        if (32'(init_r) < 32'(NUM_QUEUES)) begin
          desc_we    = 1'b1;
          desc_waddr = QW'(init_r);
          desc_wdata = DESC_CLEAR;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_data.op;
          q_nxt      = q_in;
          bin_nxt    = in_data.byte_in;
          byte_nxt   = '0;
          status_nxt = ST_DONE;
        end
      end
      S_DESC: begin
        d_nxt = desc_rd_r;
        unique case (op_r)
          OP_TAKE: begin
            if (dd_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              st_en      = 1'b1;
              st_blk     = desc_rd_r.front_blk;
              st_off     = desc_rd_r.front_off;
              link_re    = 1'b1;
              link_raddr = desc_rd_r.front_blk[LAW-1:0];
            end
          end
          OP_APPEND: begin
            if (dd_need_blk) begin
              if (pool_empty) begin
                status_nxt = ST_NOFREE;
              end else begin
                link_re    = 1'b1;
                link_raddr = free_head_r[LAW-1:0];
              end
            end else begin
              st_en          = 1'b1;
              st_we          = 1'b1;
              st_blk         = desc_rd_r.back_blk;
              st_off         = desc_rd_r.back_off;
              d_nxt.back_off = desc_rd_r.back_off + OW'(1);
              d_nxt.count    = desc_rd_r.count + CW'(1);
            end
          end
          OP_REMOVE: begin
            if (rem_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              d_nxt.back_off = desc_rd_r.back_off - OW'(1);
              st_en          = 1'b1;
              st_blk         = desc_rd_r.back_blk;
              st_off         = desc_rd_r.back_off - OW'(1);
            end
          end
          default: ;
        endcase
      end
      S_TAKE: begin
        byte_nxt        = st_rdata;
        d_nxt.front_off = front_inc;
        d_nxt.count     = d_r.count - CW'(1);
        if (take_last || take_wrap) begin
          // front block gives its last byte: back to the free list
          link_we       = 1'b1;
          link_waddr    = d_r.front_blk[LAW-1:0];
          link_wdata    = free_head_r;
          free_head_nxt = d_r.front_blk;
          free_cap_nxt  = free_cap_r + BLK_CAP;
          if (take_last) begin
            d_nxt = DESC_CLEAR;
          end else begin
            d_nxt.front_blk = link_rdata;
            d_nxt.front_off = '0;
          end
        end
      end
      S_GRAB: begin
        free_head_nxt = link_rdata;
        free_cap_nxt  = free_cap_r - BLK_CAP;
        new_blk_nxt   = free_head_r;
        prev_nxt      = d_r.back_blk;
        link_we       = 1'b1;
        link_waddr    = free_head_r[LAW-1:0];
        link_wdata    = NULL_BLK;
        st_en         = 1'b1;
        st_we         = 1'b1;
        st_blk        = free_head_r;
        st_off        = '0;
        if (grab_new_chain) begin
          d_nxt           = DESC_CLEAR;
          d_nxt.front_blk = free_head_r;
          d_nxt.back_blk  = free_head_r;
          d_nxt.count     = CW'(1);
        end else begin
          d_nxt.back_blk = free_head_r;
          d_nxt.count    = d_r.count + CW'(1);
        end
        d_nxt.back_off = OW'(1);
      end
      S_LINK: begin
        // chain the fresh block behind the old back block
        link_we    = 1'b1;
        link_waddr = prev_r[LAW-1:0];
        link_wdata = new_blk_r;
      end
      S_REM: begin
        byte_nxt    = st_rdata;
        d_nxt.count = d_r.count - CW'(1);
        if (rem_last) begin
          link_we       = 1'b1;
          link_waddr    = d_r.back_blk[LAW-1:0];
          link_wdata    = free_head_r;
          free_head_nxt = d_r.back_blk;
          free_cap_nxt  = free_cap_r + BLK_CAP;
          d_nxt         = DESC_CLEAR;
        end else if (d_r.back_off == '0) begin
          // back block emptied: search the chain for its predecessor
          prev_nxt   = d_r.front_blk;
          steps_nxt  = '0;
          link_re    = 1'b1;
          link_raddr = d_r.front_blk[LAW-1:0];
        end
      end
      S_WALK: begin
        if (walk_found) begin
          link_we       = 1'b1;
          link_waddr    = d_r.back_blk[LAW-1:0];
          link_wdata    = free_head_r;
          free_head_nxt = d_r.back_blk;
          free_cap_nxt  = free_cap_r + BLK_CAP;
        end else if (!walk_stop) begin
          prev_nxt   = link_rdata;
          steps_nxt  = steps_r + BW'(1);
          link_re    = 1'b1;
          link_raddr = link_rdata[LAW-1:0];
        end
      end
      S_UNLINK: begin
        link_we        = 1'b1;
        link_waddr     = prev_r[LAW-1:0];
        link_wdata     = NULL_BLK;
        d_nxt.back_blk = prev_r;
        d_nxt.back_off = BLK_FULL;
      end
      S_DONE: begin
        desc_we  = 1'b1;
        res_load = slot_free;
      end
      default: ;
    endcase
  end

  assign res.byte_out        = byte_r;
  assign res.status          = status_r;
  assign res.queue_bytes     = COUNT_W'(d_r.count);
  assign res.pool_free_bytes = COUNT_W'(free_cap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      free_head_r <= '0;
      free_cap_r  <= POOL_CAP;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      free_head_r <= free_head_nxt;
      free_cap_r  <= free_cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    q_r       <= q_nxt;
    bin_r     <= bin_nxt;
    byte_r    <= byte_nxt;
    status_r  <= status_nxt;
    d_r       <= d_nxt;
    new_blk_r <= new_blk_nxt;
    prev_r    <= prev_nxt;
    steps_r   <= steps_nxt;
  end

  a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cap_r <= POOL_CAP)
    else $error("free capacity above pool size");

  a_head_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r == NULL_BLK) == (free_cap_r == '0))
    else $error("free list head and capacity disagree");

  a_nofree: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r == ST_NOFREE) |-> (free_cap_r == '0))
    else $error("no-free status with blocks on the free list");

  a_fail_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r != ST_DONE) |-> (byte_r == '0))
    else $error("failed operation returns a byte");

endmodule

// ----- sv/linked_block_char_queue.sv -----
// Byte queues over a shared pool of linked blocks. One item at a time:
// take runs the descriptor and take steps; append writes into a block with
// room in the descriptor step, adds a grab step when it starts a queue,
// and grab and link steps when it links a new block; remove runs the
// descriptor and remove steps, plus walk and unlink steps when the emptied
// back block's predecessor is searched through the link memory. Empty,
// no-free and unused operations end after the descriptor step. Each step
// is one round of accesses to the descriptor, link and byte memories, all
// of which have registered reads. After reset in_stall stays high while
// the free list and queue descriptors are initialized. A finished result
// sits in an output register, so the next item is taken while it waits.
// Depends on lbcq_pkg, lbcq_ctrl, lbcq_link and lbcq_store.
module linked_block_char_queue #(
  parameter int NUM_BLOCKS  = 64,
  parameter int BLOCK_BYTES = 16,
  parameter int NUM_QUEUES  = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lbcq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lbcq_pkg::out_t out_data
);
  import lbcq_pkg::*;

  logic out_valid_r;
  out_t out_data_r;
  logic ctrl_idle, slot_free, res_load;
  out_t res;

  // output register is free once empty or being drained this cycle
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !ctrl_idle;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  lbcq_ctrl #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_QUEUES  (NUM_QUEUES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .idle      (ctrl_idle),
    .slot_free (slot_free),
    .res_load  (res_load),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res;
    end
  end

endmodule
